// ===== rtl/core/integer_text_scanner_top_defines.svh =====
// ----------------------------------------------------------------------------
// integer_text_scanner_top_defines.svh
// assertion macros used by the scanner back end (its_back)
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_SCANNER_TOP_DEFINES_SVH
`define INTEGER_TEXT_SCANNER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define ITS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define ITS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/its_pkg.sv =====
// ----------------------------------------------------------------------------
// its_pkg
// types, codes and helpers of the integer text scanner
// ----------------------------------------------------------------------------
package its_pkg;

  // register indexes
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  // base codes
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_HEX = 2'd1;
  localparam logic [1:0] BASE_BIN = 2'd2;

  // result width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  // character codes
  localparam logic [15:0] CH_TAB       = 16'h0009;
  localparam logic [15:0] CH_CR        = 16'h000D;
  localparam logic [15:0] CH_SPACE     = 16'h0020;
  localparam logic [15:0] CH_PLUS      = 16'h002B;
  localparam logic [15:0] CH_MINUS     = 16'h002D;
  localparam logic [15:0] CH_MINUS_U   = 16'h2212;
  localparam logic [15:0] CH_ZERO      = 16'h0030;
  localparam logic [15:0] CH_ONE       = 16'h0031;
  localparam logic [15:0] CH_NINE      = 16'h0039;
  localparam logic [15:0] CH_UPPER_A   = 16'h0041;
  localparam logic [15:0] CH_UPPER_F   = 16'h0046;
  localparam logic [15:0] CH_LOWER_A   = 16'h0061;
  localparam logic [15:0] CH_LOWER_F   = 16'h0066;

  // letter digits: low nibble of 'a'/'A' is 1, plus 9 gives 10
  localparam logic [3:0] LETTER_OFFSET = 4'd9;

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_PLUS,
    CL_MINUS,
    CL_DIGIT,
    CL_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT
  } phase_e;

  typedef struct packed {
    logic [1:0] base_select;
    logic       signed_mode;
    logic [1:0] result_width;
  } cfg_t;

  typedef struct packed {
    logic       start;
    cls_e       cls;
    logic [3:0] digit;
  } item_t;

  // one digit step with shifts and adds
  function automatic logic [31:0] acc_step(input logic [31:0] acc, input logic [3:0] d,
                                           input logic [1:0] base);
    logic [31:0] r;
    unique case (base)
      BASE_HEX: r = {acc[27:0], d};
      BASE_BIN: r = {acc[30:0], d[0]};
      default:  r = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, d};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/integer_text_scanner_top.sv =====
// ----------------------------------------------------------------------------
// integer_text_scanner_top
// scans integer fields from a stream of 16-bit text code units
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid_i/in_ready_o  | start_req_i, code_unit_i
//  out     | out_valid_o/out_ready_i| value_o, ok_o, consumed_o
//  cfg     | cfg_we_i               | cfg_addr_i, cfg_data_i
//
//  one code unit per cycle while the queue is not full, using the combinational shift-and-add of the executor
//  a result beat is registered: its terminating unit passes the queue entry, then the result register
//  a two-entry queue lets input take two more code units while output stalls
//  reset restores base decimal, signed mode on, 32-bit result, empty scan
// ----------------------------------------------------------------------------
module integer_text_scanner_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [15:0] code_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic        ok_o,
  output logic [15:0] consumed_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [1:0]  cfg_data_i
);

  its_pkg::cfg_t  cfg_q;
  its_pkg::item_t front_item;
  its_pkg::item_t head_item;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_select  <= its_pkg::BASE_DEC;
      cfg_q.signed_mode  <= 1'b1;
      cfg_q.result_width <= its_pkg::WIDTH_32;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        its_pkg::REG_BASE:   cfg_q.base_select  <= cfg_data_i;
        its_pkg::REG_SIGNED: cfg_q.signed_mode  <= cfg_data_i[0];
        its_pkg::REG_WIDTH:  cfg_q.result_width <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;

  // classifier
  its_front u_front (
    .cfg_i       (cfg_q),
    .start_req_i (start_req_i),
    .code_unit_i (code_unit_i),
    .item_o      (front_item)
  );

  // decoupling queue
  its_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (head_item)
  );

  // executor
  its_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (head_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .ok_o         (ok_o),
    .consumed_o   (consumed_o)
  );

endmodule

// ===== rtl/core/its_front.sv =====
// ----------------------------------------------------------------------------
// its_front
// classifies each incoming code unit for the back end
// ----------------------------------------------------------------------------
module its_front (
  input  its_pkg::cfg_t  cfg_i,
  input  logic           start_req_i,
  input  logic [15:0]    code_unit_i,
  output its_pkg::item_t item_o
);

  logic [15:0] c;
  logic        is_dec;
  logic        is_low;
  logic        is_up;

  assign c      = code_unit_i;
  assign is_dec = (c >= its_pkg::CH_ZERO) && (c <= its_pkg::CH_NINE);
  assign is_low = (c >= its_pkg::CH_LOWER_A) && (c <= its_pkg::CH_LOWER_F);
  assign is_up  = (c >= its_pkg::CH_UPPER_A) && (c <= its_pkg::CH_UPPER_F);

  // character class and digit value
  always_comb begin
    item_o.start = start_req_i;
    item_o.digit = c[3:0];
    priority if (((c >= its_pkg::CH_TAB) && (c <= its_pkg::CH_CR)) || (c == its_pkg::CH_SPACE))
    begin
      item_o.cls = its_pkg::CL_SPACE;
    end else if (c == its_pkg::CH_PLUS) begin
      item_o.cls = its_pkg::CL_PLUS;
    end else if (cfg_i.signed_mode &&
                 ((c == its_pkg::CH_MINUS) || (c == its_pkg::CH_MINUS_U))) begin
      item_o.cls = its_pkg::CL_MINUS;
    end else if (cfg_i.base_select == its_pkg::BASE_BIN) begin
      item_o.cls = ((c == its_pkg::CH_ZERO) || (c == its_pkg::CH_ONE)) ?
                   its_pkg::CL_DIGIT : its_pkg::CL_OTHER;
    end else if (is_dec) begin
      item_o.cls = its_pkg::CL_DIGIT;
    end else if ((cfg_i.base_select == its_pkg::BASE_HEX) && (is_low || is_up)) begin
      item_o.cls   = its_pkg::CL_DIGIT;
      item_o.digit = c[3:0] + its_pkg::LETTER_OFFSET;
    end else begin
      item_o.cls = its_pkg::CL_OTHER;
    end
  end

endmodule

// ===== rtl/core/its_queue.sv =====
// ----------------------------------------------------------------------------
// its_queue
// two-entry queue between classifier and executor
// ----------------------------------------------------------------------------
module its_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  its_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output its_pkg::item_t item_o
);

  its_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/its_back.sv =====
// ----------------------------------------------------------------------------
// its_back
// runs the scan state machine and holds the result beat
// ----------------------------------------------------------------------------
`include "integer_text_scanner_top_defines.svh"

module its_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  its_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  its_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    value_o,
  output logic           ok_o,
  output logic [15:0]    consumed_o
);

  localparam int CntW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  its_pkg::phase_e       phase_q, phase_d, ph;
  logic [31:0]           acc_q, acc_d, acc;
  logic                  neg_q, neg_d, ng;
  logic                  seen_q, seen_d, sn;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cn;
  logic                  emit;
  logic                  pop;

  logic                  res_valid_q, res_valid_d;
  logic [31:0]           res_value_q;
  logic                  res_ok_q;
  logic [15:0]           res_consumed_q;

  logic [31:0]           signed_val;
  logic [31:0]           shaped;
  logic [CntW-1:0]       cnt_ext;
  logic [15:0]           cnt_sat;

  assign pop        = item_valid_i && (!res_valid_q || out_ready_i);
  assign item_pop_o = pop;

  // scan step on the head item
  always_comb begin
    ph   = phase_q;
    acc  = acc_q;
    ng   = neg_q;
    sn   = seen_q;
    cn   = cnt_q;
    emit = 1'b0;
    if (item_i.start) begin
      ph  = its_pkg::PH_SPACE;
      acc = '0;
      ng  = 1'b0;
      sn  = 1'b0;
      cn  = '0;
    end
    if ((ph == its_pkg::PH_SPACE) && (item_i.cls != its_pkg::CL_SPACE)) begin
      ph = its_pkg::PH_SIGN;
    end
    if (ph == its_pkg::PH_SIGN) begin
      if (item_i.cls == its_pkg::CL_MINUS) begin
        ng = 1'b1;
      end else if (item_i.cls != its_pkg::CL_PLUS) begin
        ph = its_pkg::PH_DIGIT;
      end
    end
    if (ph == its_pkg::PH_DIGIT) begin
      if (item_i.cls == its_pkg::CL_DIGIT) begin
        acc = its_pkg::acc_step(acc, item_i.digit, cfg_i.base_select);
        sn  = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    if (pop) begin
      if (emit) begin
        phase_d = its_pkg::PH_SPACE;
        acc_d   = '0;
        neg_d   = 1'b0;
        seen_d  = 1'b0;
        cnt_d   = '0;
      end else begin
        phase_d = ph;
        acc_d   = acc;
        neg_d   = ng;
        seen_d  = sn;
        cnt_d   = (cn != '1) ? cn + 1'b1 : cn;
      end
    end
  end

  // result shaping
  always_comb begin
    signed_val = ng ? (32'd0 - acc) : acc;
    unique case (cfg_i.result_width)
      its_pkg::WIDTH_8:
        shaped = {{24{cfg_i.signed_mode & signed_val[7]}}, signed_val[7:0]};
      its_pkg::WIDTH_16:
        shaped = {{16{cfg_i.signed_mode & signed_val[15]}}, signed_val[15:0]};
      default:
        shaped = signed_val;
    endcase
    cnt_ext = CntW'(cn);
    cnt_sat = (cnt_ext > CntW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
  end

  assign res_valid_d = (pop && emit) ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= its_pkg::PH_SPACE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // scan state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      res_value_q    <= sn ? shaped : 32'd0;
      res_ok_q       <= sn;
      res_consumed_q <= sn ? cnt_sat : 16'd0;
    end
  end

  assign out_valid_o = res_valid_q;
  assign value_o     = res_value_q;
  assign ok_o        = res_ok_q;
  assign consumed_o  = res_consumed_q;

  // checks
  `ITS_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, res_valid_q && !res_ok_q,
    (res_value_q == 32'd0) && (res_consumed_q == 16'd0), "failed scan carries data")
  `ITS_ASSERT_NOW(a_ok_counted, clk_i, rst_ni, res_valid_q && res_ok_q,
    res_consumed_q != 16'd0, "successful scan consumed nothing")
  `ITS_ASSERT_NOW(a_seen_phase, clk_i, rst_ni, seen_q, phase_q == its_pkg::PH_DIGIT,
    "digit seen outside digit phase")
  `ITS_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, pop && emit,
    (phase_q == its_pkg::PH_SPACE) && (acc_q == 32'd0) && !seen_q && res_valid_q,
    "scan state not cleared after result")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_text_scanner_top. Code units go in over a
// valid/ready channel, and an in-bench scanner model predicts every result
// beat. Each beat is then checked field by field against the oldest
// prediction. Directed fields cover whitespace, sign runs, each digit set,
// the register codes and a long field. Random fields under several register
// settings and idle patterns follow.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 120;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_UNITS   = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int MAX_GAP       = 20;

  // codes the package does not name
  localparam logic [1:0] REG_NONE     = 2'd3;
  localparam logic [1:0] BASE_UNUSED  = 2'd3;
  localparam logic [1:0] WIDTH_UNUSED = 2'd3;

  localparam logic [15:0] CH_NUL      = 16'h0000;
  localparam logic [15:0] CH_BS       = 16'h0008;
  localparam logic [15:0] CH_LF       = 16'h000A;
  localparam logic [15:0] CH_SO       = 16'h000E;
  localparam logic [15:0] CH_SLASH    = 16'h002F;
  localparam logic [15:0] CH_COLON    = 16'h003A;
  localparam logic [15:0] CH_AT       = 16'h0040;
  localparam logic [15:0] CH_UPPER_B  = 16'h0042;
  localparam logic [15:0] CH_UPPER_G  = 16'h0047;
  localparam logic [15:0] CH_UPPER_X  = 16'h0058;
  localparam logic [15:0] CH_BACKTICK = 16'h0060;
  localparam logic [15:0] CH_LOWER_B  = 16'h0062;
  localparam logic [15:0] CH_LOWER_G  = 16'h0067;
  localparam logic [15:0] CH_LOWER_X  = 16'h0078;
  localparam logic [15:0] CH_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
    logic [15:0] consumed;
  } scan_result_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // dut signals
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        start_req_i = 1'b0;
  logic [15:0] code_unit_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;
  logic        ok_o;
  logic [15:0] consumed_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_addr_i  = '0;
  logic [1:0]  cfg_data_i  = '0;

  // scanner model: registers and scan state
  logic [1:0]       model_base   = its_pkg::BASE_DEC;
  logic             model_signed = 1'b1;
  logic [1:0]       model_width  = its_pkg::WIDTH_32;
  its_pkg::phase_e  scan_phase   = its_pkg::PH_SPACE;
  logic [31:0]      scan_acc     = '0;
  logic             scan_neg     = 1'b0;
  logic             scan_digit_seen = 1'b0;
  logic [15:0]      scan_count   = '0;

  scan_result_t expected_fields[$];

  int errors        = 0;
  int units_sent    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_order    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  integer_text_scanner_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .code_unit_i (code_unit_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .ok_o        (ok_o),
    .consumed_o  (consumed_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_text_scanner_top: mismatch");
      $finish;
    end
  end

  function automatic void clear_scan_model();
    scan_phase      = its_pkg::PH_SPACE;
    scan_acc        = '0;
    scan_neg        = 1'b0;
    scan_digit_seen = 1'b0;
    scan_count      = '0;
  endfunction

  // advance the scanner model by one accepted unit
  function automatic void predict_scan(input logic start, input logic [15:0] cu);
    logic         is_digit;
    logic [31:0]  digit_val;
    logic [31:0]  radix;
    logic [31:0]  shaped;
    scan_result_t res;
    if (start) clear_scan_model();
    if (scan_phase == its_pkg::PH_SPACE &&
        !((cu >= its_pkg::CH_TAB && cu <= its_pkg::CH_CR) || cu == its_pkg::CH_SPACE))
      scan_phase = its_pkg::PH_SIGN;
    if (scan_phase == its_pkg::PH_SIGN) begin
      if (cu == its_pkg::CH_PLUS) begin
        // plus is taken and changes nothing
      end else if (model_signed &&
                   (cu == its_pkg::CH_MINUS || cu == its_pkg::CH_MINUS_U)) begin
        scan_neg = 1'b1;
      end else begin
        scan_phase = its_pkg::PH_DIGIT;
      end
    end
    if (scan_phase == its_pkg::PH_DIGIT) begin
      // digit decode for the selected set
      is_digit  = 1'b0;
      digit_val = '0;
      radix     = 32'd10;
      if (model_base == its_pkg::BASE_BIN) begin
        radix = 32'd2;
        if (cu == its_pkg::CH_ZERO || cu == its_pkg::CH_ONE) begin
          is_digit  = 1'b1;
          digit_val = 32'(cu - its_pkg::CH_ZERO);
        end
      end else begin
        if (model_base == its_pkg::BASE_HEX) radix = 32'd16;
        if (cu >= its_pkg::CH_ZERO && cu <= its_pkg::CH_NINE) begin
          is_digit  = 1'b1;
          digit_val = 32'(cu - its_pkg::CH_ZERO);
        end else if (model_base == its_pkg::BASE_HEX &&
                     cu >= its_pkg::CH_LOWER_A && cu <= its_pkg::CH_LOWER_F) begin
          is_digit  = 1'b1;
          digit_val = 32'(cu - its_pkg::CH_LOWER_A) + 32'd10;
        end else if (model_base == its_pkg::BASE_HEX &&
                     cu >= its_pkg::CH_UPPER_A && cu <= its_pkg::CH_UPPER_F) begin
          is_digit  = 1'b1;
          digit_val = 32'(cu - its_pkg::CH_UPPER_A) + 32'd10;
        end
      end
      if (is_digit) begin
        scan_acc        = scan_acc * radix + digit_val;
        scan_digit_seen = 1'b1;
      end else begin
        // field ends here, terminating unit is not counted
        if (scan_digit_seen) begin
          shaped = scan_neg ? (32'd0 - scan_acc) : scan_acc;
          case (model_width)
            its_pkg::WIDTH_8:
              shaped = {{24{model_signed & shaped[7]}}, shaped[7:0]};
            its_pkg::WIDTH_16:
              shaped = {{16{model_signed & shaped[15]}}, shaped[15:0]};
            default:  ;
          endcase
          res = '{value: shaped, ok: 1'b1, consumed: scan_count};
        end else begin
          res = '{value: '0, ok: 1'b0, consumed: '0};
        end
        expected_fields.push_back(res);
        clear_scan_model();
        return;
      end
    end
    if (scan_count != '1) scan_count++;
  endfunction

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t %s: expected %h, actual %h", $time, what, want, got);
  endtask

  // result check and receiver ready
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fields.size() == 0) begin
        report_field("beat with nothing expected, value", 32'hx, value_o);
      end else begin
        want = expected_fields.pop_front();
        if (value_o !== want.value) report_field("value", want.value, value_o);
        if (ok_o !== want.ok) report_field("ok", 32'(want.ok), 32'(ok_o));
        if (consumed_o !== want.consumed)
          report_field("consumed", 32'(want.consumed), 32'(consumed_o));
      end
    end
    if (hold_order != hold_taken) begin
      hold_taken = hold_order;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input beat, with an optional idle gap before it
  task automatic send_unit(input logic start, input logic [15:0] cu);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start;
    code_unit_i <= cu;
    do @(posedge clk_i); while (!in_ready_o);
    predict_scan(start, cu);
    units_sent++;
  endtask

  // stop sending and let every pending beat come out
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [1:0] data);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      its_pkg::REG_BASE:   model_base   = data;
      its_pkg::REG_SIGNED: model_signed = data[0];
      its_pkg::REG_WIDTH:  model_width  = data;
      default:    ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] base, input logic sgn, input logic [1:0] width);
    set_register(its_pkg::REG_BASE, base);
    set_register(its_pkg::REG_SIGNED, {1'b0, sgn});
    set_register(its_pkg::REG_WIDTH, width);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  function automatic logic [15:0] blank_unit();
    if ($urandom_range(2) == 0) return its_pkg::CH_SPACE;
    return its_pkg::CH_TAB + 16'($urandom_range(4));
  endfunction

  // a digit of the current set
  function automatic logic [15:0] digit_unit();
    if (model_base == its_pkg::BASE_BIN) return its_pkg::CH_ZERO + 16'($urandom_range(1));
    if (model_base == its_pkg::BASE_HEX) begin
      case ($urandom_range(2))
        0:       return its_pkg::CH_LOWER_A + 16'($urandom_range(5));
        1:       return its_pkg::CH_UPPER_A + 16'($urandom_range(5));
        default: return its_pkg::CH_ZERO + 16'($urandom_range(9));
      endcase
    end
    return its_pkg::CH_ZERO + 16'($urandom_range(9));
  endfunction

  // any unit, weighted toward the interesting classes
  function automatic logic [15:0] pick_unit();
    case ($urandom_range(11))
      0:  return 16'($urandom);
      1:  return blank_unit();
      2:  return its_pkg::CH_PLUS;
      3:  return its_pkg::CH_MINUS;
      4:  return its_pkg::CH_MINUS_U;
      5:  return digit_unit();
      6:  return CH_NUL;
      7:  return CH_MAX;
      8: begin
        case ($urandom_range(7))
          0:       return CH_SLASH;
          1:       return CH_COLON;
          2:       return CH_AT;
          3:       return CH_UPPER_G;
          4:       return CH_BACKTICK;
          5:       return CH_LOWER_G;
          6:       return CH_BS;
          default: return CH_SO;
        endcase
      end
      9:  return its_pkg::CH_MINUS_U + 16'($urandom_range(2)) - 16'd1;
      10: begin
        case ($urandom_range(3))
          0:       return CH_LOWER_X;
          1:       return CH_UPPER_X;
          2:       return CH_LOWER_B;
          default: return CH_UPPER_B;
        endcase
      end
      default: return ($urandom_range(1) ? its_pkg::CH_UPPER_A : its_pkg::CH_LOWER_A) +
                      16'($urandom_range(5));
    endcase
  endfunction

  // mostly well-formed fields, some broken ones and some raw noise
  task automatic send_random_field();
    int   roll;
    int   n;
    logic start;
    roll  = $urandom_range(99);
    start = ($urandom_range(7) == 0);
    if (roll < 80) begin
      n = $urandom_range(3);
      repeat (n) begin
        send_unit(start, blank_unit());
        start = 1'b0;
      end
      n = $urandom_range(3);
      repeat (n) begin
        case ($urandom_range(2))
          0:       send_unit(start, its_pkg::CH_PLUS);
          1:       send_unit(start, its_pkg::CH_MINUS);
          default: send_unit(start, its_pkg::CH_MINUS_U);
        endcase
        start = 1'b0;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      repeat (n) begin
        send_unit(start, digit_unit());
        start = 1'b0;
      end
      send_unit(1'b0, pick_unit());
    end else if (roll < 92) begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        send_unit(start, pick_unit());
        start = ($urandom_range(15) == 0);
      end
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_unit(1'($urandom_range(1)), 16'($urandom));
    end
  endtask

  // reset settings: decimal, signed, 32 bits
  task automatic test_reset_defaults();
    set_idle(IDLE_NONE);
    // blanks, a mixed sign run, digits, text end
    send_unit(1'b1, its_pkg::CH_SPACE);
    send_unit(1'b0, its_pkg::CH_TAB);
    send_unit(1'b0, CH_LF);
    send_unit(1'b0, its_pkg::CH_CR);
    send_unit(1'b0, its_pkg::CH_MINUS);
    send_unit(1'b0, its_pkg::CH_PLUS);
    send_unit(1'b0, its_pkg::CH_MINUS_U);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, CH_NUL);
    // no digit at all
    send_unit(1'b0, CH_MAX);
    send_unit(1'b0, CH_BS);
    send_unit(1'b0, CH_SO);
    // digit range edges
    send_unit(1'b0, its_pkg::CH_ZERO);
    send_unit(1'b0, CH_SLASH);
    send_unit(1'b0, its_pkg::CH_NINE);
    // start request drops the partial field
    send_unit(1'b1, its_pkg::CH_ONE);
    send_unit(1'b0, CH_COLON);
    // sign with no digit
    send_unit(1'b0, its_pkg::CH_MINUS);
    send_unit(1'b0, its_pkg::CH_UPPER_A);
  endtask

  task automatic test_digit_sets();
    set_idle(IDLE_BOTH);
    configure(its_pkg::BASE_HEX, 1'b1, its_pkg::WIDTH_32);
    send_unit(1'b1, its_pkg::CH_ZERO);
    send_unit(1'b0, CH_LOWER_B);
    send_unit(1'b0, its_pkg::CH_UPPER_F);
    send_unit(1'b0, its_pkg::CH_LOWER_F);
    send_unit(1'b0, its_pkg::CH_UPPER_A);
    send_unit(1'b0, its_pkg::CH_LOWER_A);
    send_unit(1'b0, CH_LOWER_X);
    send_unit(1'b0, CH_UPPER_G);
    send_unit(1'b0, CH_LOWER_G);
    send_unit(1'b0, CH_AT);
    send_unit(1'b0, CH_BACKTICK);
    send_unit(1'b0, its_pkg::CH_MINUS_U);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, CH_UPPER_X);
    configure(its_pkg::BASE_BIN, 1'b1, its_pkg::WIDTH_16);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_ZERO);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, CH_LOWER_B);
    send_unit(1'b0, its_pkg::CH_MINUS);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, CH_UPPER_B);
  endtask

  // masking, ignored index, unused codes, truncation
  task automatic test_register_writes();
    set_idle(IDLE_NONE);
    configure(its_pkg::BASE_DEC, 1'b1, its_pkg::WIDTH_32);
    // upper data bit is dropped, so signed mode goes off
    set_register(its_pkg::REG_SIGNED, 2'b10);
    send_unit(1'b1, its_pkg::CH_MINUS);
    send_unit(1'b0, its_pkg::CH_PLUS);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, its_pkg::CH_MINUS);
    // 8-bit unsigned then signed
    set_register(its_pkg::REG_WIDTH, its_pkg::WIDTH_8);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, CH_NUL);
    set_register(its_pkg::REG_SIGNED, 2'b11);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, its_pkg::CH_NINE);
    send_unit(1'b0, CH_NUL);
    // write past the register list changes nothing
    set_register(REG_NONE, 2'b01);
    set_register(its_pkg::REG_WIDTH, WIDTH_UNUSED);
    send_unit(1'b0, its_pkg::CH_MINUS);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, CH_NUL);
    set_register(its_pkg::REG_BASE, BASE_UNUSED);
    send_unit(1'b0, its_pkg::CH_ONE);
    send_unit(1'b0, its_pkg::CH_ZERO);
    send_unit(1'b0, its_pkg::CH_UPPER_A);
  endtask

  // receiver holds off while the sender keeps pushing short fields
  task automatic test_full_backpressure();
    configure(its_pkg::BASE_DEC, 1'b1, its_pkg::WIDTH_16);
    set_idle(IDLE_NONE);
    hold_order <= hold_order + 1;
    repeat (40) begin
      send_unit(1'b0, digit_unit());
      send_unit(1'b0, its_pkg::CH_SPACE);
    end
  endtask

  // long field with many leading blanks and digits
  task automatic test_long_field();
    configure(its_pkg::BASE_DEC, 1'b1, its_pkg::WIDTH_32);
    set_idle(IDLE_NONE);
    send_unit(1'b1, its_pkg::CH_SPACE);
    repeat (59) send_unit(1'b0, blank_unit());
    repeat (40) send_unit(1'b0, digit_unit());
    send_unit(1'b0, CH_NUL);
  endtask

  // random fields over a walk of settings and idle patterns
  task automatic test_random_fields();
    int first;
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      configure(2'(k % 4), 1'((k / 2) % 2), 2'((k + k / 4) % 4));
      set_idle(idle_mode_e'((k + k / 2) % 4));
      first = units_sent;
      while (units_sent - first < PHASE_UNITS) send_random_field();
    end
  endtask

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_digit_sets();
    test_register_writes();
    test_full_backpressure();
    test_long_field();
    test_random_fields();
    settle_block();
    if (errors == 0) begin
      $display("integer_text_scanner_top: match");
    end else begin
      $display("integer_text_scanner_top: mismatch");
    end
    $finish;
  end

endmodule
